// ===== design/fpsc_pkg.sv =====
// Shared types and constants for the flash pattern status classifier.
`timescale 1ns / 1ps
`default_nettype none

package fpsc_pkg;

    typedef logic [2:0]  gate_state_t;
    typedef logic [31:0] ms_time_t;
    typedef logic [15:0] cfg_word_t;
    typedef logic [2:0]  cfg_index_t;
    typedef logic [9:0]  fault_centre_t;

    // gate state codes
    localparam gate_state_t ST_UNKNOWN = 3'd0;
    localparam gate_state_t ST_OPEN    = 3'd1;
    localparam gate_state_t ST_OPENING = 3'd2;
    localparam gate_state_t ST_CLOSED  = 3'd3;
    localparam gate_state_t ST_CLOSING = 3'd4;
    localparam gate_state_t ST_FAULT   = 3'd5;

    // configuration register indexes
    localparam cfg_index_t REG_DEBOUNCE      = 3'd0;
    localparam cfg_index_t REG_STEADY        = 3'd1;
    localparam cfg_index_t REG_SLOW_MIN      = 3'd2;
    localparam cfg_index_t REG_SLOW_MAX      = 3'd3;
    localparam cfg_index_t REG_FAST_MIN      = 3'd4;
    localparam cfg_index_t REG_FAST_MAX      = 3'd5;
    localparam cfg_index_t REG_FAULT_TOL     = 3'd6;
    localparam cfg_index_t REG_ACTIVE_HIGH   = 3'd7;

    // register reset values
    localparam cfg_word_t RST_DEBOUNCE  = 16'd50;
    localparam cfg_word_t RST_STEADY    = 16'd3000;
    localparam cfg_word_t RST_SLOW_MIN  = 16'd800;
    localparam cfg_word_t RST_SLOW_MAX  = 16'd1200;
    localparam cfg_word_t RST_FAST_MIN  = 16'd200;
    localparam cfg_word_t RST_FAST_MAX  = 16'd400;
    localparam cfg_word_t RST_FAULT_TOL = 16'd30;

    // fault flash periods: 1000 ms divided by 1..5
    localparam int FAULT_BANDS = 5;
    localparam int FAULT_BASE_MS = 1000;
    localparam fault_centre_t FAULT_CENTRE_MS [FAULT_BANDS] = '{
        fault_centre_t'(FAULT_BASE_MS / 1),
        fault_centre_t'(FAULT_BASE_MS / 2),
        fault_centre_t'(FAULT_BASE_MS / 3),
        fault_centre_t'(FAULT_BASE_MS / 4),
        fault_centre_t'(FAULT_BASE_MS / 5)
    };

endpackage

`default_nettype wire

// ===== design/flash_pattern_status_classifier_core.sv =====
// Top level of the flash pattern status classifier: debounce, edge period and state decision.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  s_      | in        | s_valid / s_ready  | s_raw_sample (1), s_now_ms (32)
//  m_      | out       | m_valid / m_ready  | m_gate_state (3), m_state_changed (1)
//  cfg_    | in        | cfg_wr_en only     | cfg_index (3), cfg_wdata (16)
//
// One beat per cycle while m_ready is high; beats go through the input and result registers.
// Stage 1 is the input register; stage 2 runs the debounce, period and band
// compares in one pass and loads the result register plus the tracking state.
// aresetn (synchronous, active low) loads register defaults, clears valid and tracking state.
// When m_ready is low a full result register holds; one more beat waits in the
// input register and s_ready drops only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module flash_pattern_status_classifier_core (
    input  wire                      aclk,
    input  wire                      aresetn,

    input  wire                      s_valid,
    output logic                     s_ready,
    input  wire                      s_raw_sample,
    input  wire  [31:0]              s_now_ms,

    output logic                     m_valid,
    input  wire                      m_ready,
    output fpsc_pkg::gate_state_t    m_gate_state,
    output logic                     m_state_changed,

    input  wire                      cfg_wr_en,
    input  wire  [2:0]               cfg_index,
    input  wire  [15:0]              cfg_wdata
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    fpsc_pkg::cfg_word_t debounce_reg;
    fpsc_pkg::cfg_word_t steady_reg;
    fpsc_pkg::cfg_word_t slow_min_reg;
    fpsc_pkg::cfg_word_t slow_max_reg;
    fpsc_pkg::cfg_word_t fast_min_reg;
    fpsc_pkg::cfg_word_t fast_max_reg;
    fpsc_pkg::cfg_word_t fault_tol_reg;
    logic                active_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg    <= fpsc_pkg::RST_DEBOUNCE;
            steady_reg      <= fpsc_pkg::RST_STEADY;
            slow_min_reg    <= fpsc_pkg::RST_SLOW_MIN;
            slow_max_reg    <= fpsc_pkg::RST_SLOW_MAX;
            fast_min_reg    <= fpsc_pkg::RST_FAST_MIN;
            fast_max_reg    <= fpsc_pkg::RST_FAST_MAX;
            fault_tol_reg   <= fpsc_pkg::RST_FAULT_TOL;
            active_high_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                fpsc_pkg::REG_DEBOUNCE:    debounce_reg    <= cfg_wdata;
                fpsc_pkg::REG_STEADY:      steady_reg      <= cfg_wdata;
                fpsc_pkg::REG_SLOW_MIN:    slow_min_reg    <= cfg_wdata;
                fpsc_pkg::REG_SLOW_MAX:    slow_max_reg    <= cfg_wdata;
                fpsc_pkg::REG_FAST_MIN:    fast_min_reg    <= cfg_wdata;
                fpsc_pkg::REG_FAST_MAX:    fast_max_reg    <= cfg_wdata;
                fpsc_pkg::REG_FAULT_TOL:   fault_tol_reg   <= cfg_wdata;
                fpsc_pkg::REG_ACTIVE_HIGH: active_high_reg <= cfg_wdata[0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage 1: input register
    // ------------------------------------------------------------------
    logic                 in_valid_reg;
    logic                 in_raw_reg;
    fpsc_pkg::ms_time_t   in_now_reg;
    logic                 advance;   // stage 2 consumes the input register

    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_raw_reg <= s_raw_sample;
            in_now_reg <= s_now_ms;
        end
    end

    // ------------------------------------------------------------------
    // tracking state
    // ------------------------------------------------------------------
    fpsc_pkg::gate_state_t held_state_reg, held_state_next;
    logic                  raw_seen_reg, raw_seen_next;
    fpsc_pkg::ms_time_t    raw_change_reg, raw_change_next;
    logic                  clean_level_reg, clean_level_next;
    logic                  edge_seen_reg, edge_seen_next;
    fpsc_pkg::ms_time_t    edge_time_reg, edge_time_next;
    logic                  period_valid_reg, period_valid_next;
    fpsc_pkg::ms_time_t    edge_period_reg, edge_period_next;
    fpsc_pkg::ms_time_t    steady_start_reg, steady_start_next;

    // ------------------------------------------------------------------
    // stage 2: debounce and edge capture
    // ------------------------------------------------------------------
    fpsc_pkg::ms_time_t since_raw;
    fpsc_pkg::ms_time_t since_steady;
    logic               raw_moved;
    logic               edge_take;

    assign since_raw = in_now_reg - raw_change_reg;
    assign raw_moved = in_raw_reg != raw_seen_reg;
    // a raw level that held long enough and differs from the clean level is an edge
    assign edge_take = !raw_moved && (since_raw >= {16'd0, debounce_reg})
                       && (clean_level_reg != raw_seen_reg);

    always_comb begin
        raw_seen_next     = raw_seen_reg;
        raw_change_next   = raw_change_reg;
        clean_level_next  = clean_level_reg;
        edge_seen_next    = edge_seen_reg;
        edge_time_next    = edge_time_reg;
        period_valid_next = period_valid_reg;
        edge_period_next  = edge_period_reg;
        steady_start_next = steady_start_reg;
        if (raw_moved) begin
            raw_seen_next   = in_raw_reg;
            raw_change_next = in_now_reg;
        end else if (edge_take) begin
            // first edge only arms the period timer
            if (edge_seen_reg) begin
                edge_period_next  = in_now_reg - edge_time_reg;
                period_valid_next = 1'b1;
            end
            edge_time_next    = in_now_reg;
            edge_seen_next    = 1'b1;
            clean_level_next  = raw_seen_reg;
            steady_start_next = in_now_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: classification against the updated state
    // ------------------------------------------------------------------
    logic                      lit;
    logic                      slow_hit;
    logic                      fast_hit;
    logic [fpsc_pkg::FAULT_BANDS-1:0] fault_hit;
    fpsc_pkg::fault_centre_t   fault_lo [fpsc_pkg::FAULT_BANDS];
    logic [16:0]               fault_hi [fpsc_pkg::FAULT_BANDS];

    assign since_steady = in_now_reg - steady_start_next;
    assign lit          = active_high_reg ? clean_level_next : !clean_level_next;
    assign slow_hit = (edge_period_next >= {16'd0, slow_min_reg})
                      && (edge_period_next <= {16'd0, slow_max_reg});
    assign fast_hit = (edge_period_next >= {16'd0, fast_min_reg})
                      && (edge_period_next <= {16'd0, fast_max_reg});

    always_comb begin
        for (int n = 0; n < fpsc_pkg::FAULT_BANDS; n++) begin
            // lower bound clamps at zero when the tolerance reaches the fault centre
            if ({6'd0, fpsc_pkg::FAULT_CENTRE_MS[n]} > fault_tol_reg) begin
                fault_lo[n] = fpsc_pkg::FAULT_CENTRE_MS[n] - fault_tol_reg[9:0];
            end else begin
                fault_lo[n] = '0;
            end
            fault_hi[n] = {7'd0, fpsc_pkg::FAULT_CENTRE_MS[n]} + {1'b0, fault_tol_reg};
            fault_hit[n] = (edge_period_next >= {22'd0, fault_lo[n]})
                           && (edge_period_next <= {15'd0, fault_hi[n]});
        end
    end

    always_comb begin
        priority if (since_steady >= {16'd0, steady_reg}) begin
            held_state_next = lit ? fpsc_pkg::ST_OPEN : fpsc_pkg::ST_CLOSED;
        end else if (period_valid_next && slow_hit) begin
            held_state_next = fpsc_pkg::ST_OPENING;
        end else if (period_valid_next && fast_hit) begin
            held_state_next = fpsc_pkg::ST_CLOSING;
        end else if (period_valid_next && (|fault_hit)) begin
            held_state_next = fpsc_pkg::ST_FAULT;
        end else begin
            held_state_next = held_state_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_state_reg   <= fpsc_pkg::ST_UNKNOWN;
            raw_seen_reg     <= 1'b0;
            raw_change_reg   <= '0;
            clean_level_reg  <= 1'b0;
            edge_seen_reg    <= 1'b0;
            edge_time_reg    <= '0;
            period_valid_reg <= 1'b0;
            edge_period_reg  <= '0;
            steady_start_reg <= '0;
        end else if (advance) begin
            held_state_reg   <= held_state_next;
            raw_seen_reg     <= raw_seen_next;
            raw_change_reg   <= raw_change_next;
            clean_level_reg  <= clean_level_next;
            edge_seen_reg    <= edge_seen_next;
            edge_time_reg    <= edge_time_next;
            period_valid_reg <= period_valid_next;
            edge_period_reg  <= edge_period_next;
            steady_start_reg <= steady_start_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (advance) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_gate_state    <= held_state_next;
            m_state_changed <= held_state_next != held_state_reg;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a waiting result always matches the state that the next beat compares against
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_gate_state == held_state_reg))
        else $error("result state out of step with held state");

    // changed flag reflects a real move of the held state
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (m_state_changed == (held_state_reg != $past(held_state_reg))))
        else $error("state_changed flag disagrees with held state update");

    // a period exists only after an edge was seen
    assert property (@(posedge aclk) disable iff (!aresetn)
        period_valid_reg |-> edge_seen_reg)
        else $error("period valid without a prior edge");

    // a beat parked in the input register is not dropped
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_now_reg)))
        else $error("input register lost a waiting beat");

endmodule

`default_nettype wire

// ===== test/flash_pattern_status_classifier_core_tb.sv =====
// Self-checking testbench for the flash pattern status classifier core.
`timescale 1ns / 1ps

module flash_pattern_status_classifier_core_tb;

    // Longest run of cycles with no beat on either channel before giving up.
    // A correct run only idles for the random gaps on both sides, the
    // two-stage pipe and a register write pause.
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        fpsc_pkg::gate_state_t state;
        logic                  changed;
    } gate_beat_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_raw_sample;
    logic [31:0]           s_now_ms;
    logic                  m_valid;
    logic                  m_ready;
    fpsc_pkg::gate_state_t m_gate_state;
    logic                  m_state_changed;
    logic                  cfg_wr_en;
    logic [2:0]            cfg_index;
    logic [15:0]           cfg_wdata;

    flash_pattern_status_classifier_core uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_raw_sample    (s_raw_sample),
        .s_now_ms        (s_now_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_gate_state    (m_gate_state),
        .m_state_changed (m_state_changed),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Predictor: register copy and tracking state of the classifier
    // ------------------------------------------------------------------
    fpsc_pkg::cfg_word_t   deb_ms;
    fpsc_pkg::cfg_word_t   steady_ms;
    fpsc_pkg::cfg_word_t   slow_lo;
    fpsc_pkg::cfg_word_t   slow_hi;
    fpsc_pkg::cfg_word_t   fast_lo;
    fpsc_pkg::cfg_word_t   fast_hi;
    fpsc_pkg::cfg_word_t   tol_ms;
    logic                  lit_high;

    fpsc_pkg::gate_state_t held;
    logic                  raw_seen;
    fpsc_pkg::ms_time_t    raw_change_at;
    logic                  clean_lvl;
    logic                  had_edge;
    fpsc_pkg::ms_time_t    edge_at;
    logic                  have_period;
    fpsc_pkg::ms_time_t    period_ms;
    fpsc_pkg::ms_time_t    steady_from;

    gate_beat_t  pending_states [$];   // expected result beats, oldest first
    int unsigned fails;
    int unsigned ticks_sent;
    int unsigned idle_cycles;
    bit          running;

    // stimulus-side bookkeeping
    fpsc_pkg::ms_time_t clock_ms;     // timestamp of the next generated sample
    logic               last_raw;
    bit                 src_calm;     // sender never idles while set
    bit                 sink_calm;    // receiver never stalls while set

    function automatic void clear_predictor();
        deb_ms        = fpsc_pkg::RST_DEBOUNCE;
        steady_ms     = fpsc_pkg::RST_STEADY;
        slow_lo       = fpsc_pkg::RST_SLOW_MIN;
        slow_hi       = fpsc_pkg::RST_SLOW_MAX;
        fast_lo       = fpsc_pkg::RST_FAST_MIN;
        fast_hi       = fpsc_pkg::RST_FAST_MAX;
        tol_ms        = fpsc_pkg::RST_FAULT_TOL;
        lit_high      = 1'b1;
        held          = fpsc_pkg::ST_UNKNOWN;
        raw_seen      = 1'b0;
        raw_change_at = '0;
        clean_lvl     = 1'b0;
        had_edge      = 1'b0;
        edge_at       = '0;
        have_period   = 1'b0;
        period_ms     = '0;
        steady_from   = '0;
    endfunction

    function automatic void set_register(input fpsc_pkg::cfg_index_t idx,
                                         input fpsc_pkg::cfg_word_t data);
        case (idx)
            fpsc_pkg::REG_DEBOUNCE:    deb_ms    = data;
            fpsc_pkg::REG_STEADY:      steady_ms = data;
            fpsc_pkg::REG_SLOW_MIN:    slow_lo   = data;
            fpsc_pkg::REG_SLOW_MAX:    slow_hi   = data;
            fpsc_pkg::REG_FAST_MIN:    fast_lo   = data;
            fpsc_pkg::REG_FAST_MAX:    fast_hi   = data;
            fpsc_pkg::REG_FAULT_TOL:   tol_ms    = data;
            fpsc_pkg::REG_ACTIVE_HIGH: lit_high  = data[0];
            default: ;
        endcase
    endfunction

    // Debounce one sample, track the edge period, then classify.
    function automatic gate_beat_t classify_tick(input logic raw,
                                                 input fpsc_pkg::ms_time_t now);
        gate_beat_t            res;
        fpsc_pkg::gate_state_t nxt;
        fpsc_pkg::ms_time_t    dt;
        fpsc_pkg::ms_time_t    centre;
        fpsc_pkg::ms_time_t    tol;
        fpsc_pkg::ms_time_t    lo;
        fpsc_pkg::ms_time_t    hi;
        logic                  lit;
        bit                    hit;

        dt = now - raw_change_at;
        if (raw != raw_seen) begin
            raw_change_at = now;
            raw_seen      = raw;
        end else if (dt >= fpsc_pkg::ms_time_t'(deb_ms) && clean_lvl != raw_seen) begin
            // first accepted edge only stamps the time, no period yet
            if (had_edge) begin
                period_ms   = now - edge_at;
                have_period = 1'b1;
            end
            edge_at     = now;
            had_edge    = 1'b1;
            clean_lvl   = raw_seen;
            steady_from = now;
        end

        lit = lit_high ? clean_lvl : ~clean_lvl;
        nxt = held;
        dt  = now - steady_from;
        if (dt >= fpsc_pkg::ms_time_t'(steady_ms)) begin
            nxt = lit ? fpsc_pkg::ST_OPEN : fpsc_pkg::ST_CLOSED;
        end else if (have_period) begin
            // slow band wins over fast band, both over the fault bands
            if (period_ms >= fpsc_pkg::ms_time_t'(slow_lo)
                && period_ms <= fpsc_pkg::ms_time_t'(slow_hi)) begin
                nxt = fpsc_pkg::ST_OPENING;
            end else if (period_ms >= fpsc_pkg::ms_time_t'(fast_lo)
                         && period_ms <= fpsc_pkg::ms_time_t'(fast_hi)) begin
                nxt = fpsc_pkg::ST_CLOSING;
            end else begin
                hit = 1'b0;
                tol = fpsc_pkg::ms_time_t'(tol_ms);
                for (int n = 1; n <= fpsc_pkg::FAULT_BANDS; n++) begin
                    centre = fpsc_pkg::ms_time_t'(fpsc_pkg::FAULT_BASE_MS / n);
                    lo     = (centre > tol) ? centre - tol : '0;  // floor at zero
                    hi     = centre + tol;
                    if (period_ms >= lo && period_ms <= hi) hit = 1'b1;
                end
                if (hit) nxt = fpsc_pkg::ST_FAULT;
            end
        end

        res.state   = nxt;
        res.changed = (nxt != held);
        held        = nxt;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on every input beat, checks every result beat,
    // and runs the stall watchdog.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        gate_beat_t want;
        bit         moved;

        if (running) begin
            moved = 1'b0;
            if (s_valid && s_ready) begin
                moved = 1'b1;
                pending_states.push_back(classify_tick(s_raw_sample, s_now_ms));
            end
            if (m_valid && m_ready) begin
                moved = 1'b1;
                if (pending_states.size() == 0) begin
                    $error("result beat with nothing expected: gate_state %0d changed %0b",
                           m_gate_state, m_state_changed);
                    fails++;
                end else begin
                    want = pending_states.pop_front();
                    if (m_gate_state !== want.state) begin
                        $error("gate_state mismatch: expected %0d, actual %0d",
                               want.state, m_gate_state);
                        fails++;
                    end
                    if (m_state_changed !== want.changed) begin
                        $error("state_changed mismatch: expected %0b, actual %0b",
                               want.changed, m_state_changed);
                        fails++;
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: a random stall before each beat
    // ------------------------------------------------------------------
    initial begin : result_sink
        int unsigned hold;

        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            hold = sink_calm ? 0 : $urandom_range(0, 14);
            if (hold != 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid === 1'b1 && m_ready === 1'b1));
            @(negedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // One input beat; called and returns at a falling edge. Valid stays
    // high across back-to-back beats.
    task automatic send_tick(input logic raw, input fpsc_pkg::ms_time_t now);
        int unsigned gap;

        gap = src_calm ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_raw_sample <= raw;
        s_now_ms     <= now;
        do @(posedge aclk); while (s_ready !== 1'b1);
        @(negedge aclk);
        last_raw = raw;
        ticks_sent++;
    endtask

    // Drop valid and let every expected beat come out, then a short pause
    // for the two pipeline stages.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_states.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // All eight registers, one per cycle, only once the block is idle.
    task automatic program_registers(input fpsc_pkg::cfg_word_t deb,
                                     input fpsc_pkg::cfg_word_t steady,
                                     input fpsc_pkg::cfg_word_t smin,
                                     input fpsc_pkg::cfg_word_t smax,
                                     input fpsc_pkg::cfg_word_t fmin,
                                     input fpsc_pkg::cfg_word_t fmax,
                                     input fpsc_pkg::cfg_word_t tol,
                                     input fpsc_pkg::cfg_word_t act);
        fpsc_pkg::cfg_word_t words [8];

        wait_idle();
        words[fpsc_pkg::REG_DEBOUNCE]    = deb;
        words[fpsc_pkg::REG_STEADY]      = steady;
        words[fpsc_pkg::REG_SLOW_MIN]    = smin;
        words[fpsc_pkg::REG_SLOW_MAX]    = smax;
        words[fpsc_pkg::REG_FAST_MIN]    = fmin;
        words[fpsc_pkg::REG_FAST_MAX]    = fmax;
        words[fpsc_pkg::REG_FAULT_TOL]   = tol;
        words[fpsc_pkg::REG_ACTIVE_HIGH] = act;
        for (int i = 0; i < 8; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= fpsc_pkg::cfg_index_t'(i);
            cfg_wdata <= words[i];
            set_register(fpsc_pkg::cfg_index_t'(i), words[i]);
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Random register set. Bands sometimes come out inverted (min above max),
    // tolerance sometimes exceeds every fault period; wild picks any 16 bits.
    task automatic roll_registers(input int unsigned deb_top, input bit wild);
        fpsc_pkg::cfg_word_t deb, steady, smin, smax, fmin, fmax, tol, act;

        deb    = fpsc_pkg::cfg_word_t'($urandom_range(0, deb_top));
        steady = ($urandom_range(0, 4) == 0)
                 ? fpsc_pkg::cfg_word_t'($urandom_range(0, 65535))
                 : fpsc_pkg::cfg_word_t'($urandom_range(1500, 65535));
        smin   = fpsc_pkg::cfg_word_t'($urandom_range(500, 1500));
        smax   = ($urandom_range(0, 4) == 0)
                 ? fpsc_pkg::cfg_word_t'(32'(smin) - $urandom_range(1, 50))
                 : fpsc_pkg::cfg_word_t'(32'(smin) + $urandom_range(0, 500));
        fmin   = fpsc_pkg::cfg_word_t'($urandom_range(100, 600));
        fmax   = ($urandom_range(0, 4) == 0)
                 ? fpsc_pkg::cfg_word_t'(32'(fmin) - $urandom_range(1, 50))
                 : fpsc_pkg::cfg_word_t'(32'(fmin) + $urandom_range(0, 300));
        case ($urandom_range(0, 5))
            0:       tol = '0;
            1:       tol = 16'hFFFF;
            default: tol = fpsc_pkg::cfg_word_t'($urandom_range(0, 80));
        endcase
        act = fpsc_pkg::cfg_word_t'($urandom);   // only bit 0 matters
        if (wild) begin
            if ($urandom_range(0, 1)) steady = fpsc_pkg::cfg_word_t'($urandom);
            if ($urandom_range(0, 1)) smin   = fpsc_pkg::cfg_word_t'($urandom);
            if ($urandom_range(0, 1)) smax   = fpsc_pkg::cfg_word_t'($urandom);
            if ($urandom_range(0, 1)) fmin   = fpsc_pkg::cfg_word_t'($urandom);
            if ($urandom_range(0, 1)) fmax   = fpsc_pkg::cfg_word_t'($urandom);
        end
        program_registers(deb, steady, smin, smax, fmin, fmax, tol, act);
    endtask

    task automatic pick_pacing();
        src_calm  = ($urandom_range(0, 4) == 0);
        sink_calm = ($urandom_range(0, 4) == 0);
    endtask

    // One level segment of dur ms starting at clock_ms. The sample at the
    // debounce point lands exactly, so back-to-back segments give an edge
    // period equal to dur. glitch_pct flips the early sample now and then.
    task automatic send_segment(input logic level, input int unsigned dur,
                                input int unsigned glitch_pct);
        fpsc_pkg::ms_time_t start;
        int unsigned        settle;

        start  = clock_ms;
        settle = (deb_ms == 16'd0) ? 32'd1 : 32'(deb_ms);
        send_tick(level, start);
        if (settle < dur) begin
            if (settle > 1 && $urandom_range(0, 2) == 0) begin
                send_tick(($urandom_range(0, 99) < glitch_pct) ? ~level : level,
                          start + $urandom_range(1, settle - 1));
            end
            send_tick(level, start + settle);
            if (settle + 1 < dur && $urandom_range(0, 2) == 0)
                send_tick(level, start + $urandom_range(settle + 1, dur - 1));
        end else if (dur > 1 && $urandom_range(0, 1) == 1) begin
            send_tick(level, start + $urandom_range(1, dur - 1));
        end
        clock_ms = start + dur;
    endtask

    // Hold a level long enough for the steady timer to call open or closed.
    task automatic steady_hold(input logic level);
        int unsigned settle;

        settle = (deb_ms == 16'd0) ? 32'd1 : 32'(deb_ms);
        send_segment(level, settle + 32'(steady_ms) + 1 + $urandom_range(0, 20), 0);
        send_tick(level, clock_ms - 1);
    endtask

    // Edge period aimed at a band boundary, a fault centre or anywhere.
    function automatic int unsigned pick_period();
        int c;
        int t;
        int p;

        c = fpsc_pkg::FAULT_BASE_MS / int'($urandom_range(1, fpsc_pkg::FAULT_BANDS));
        t = int'(tol_ms);
        case ($urandom_range(0, 11))
            0:       p = int'(slow_lo);
            1:       p = int'(slow_hi);
            2:       p = int'(slow_lo) - 1;
            3:       p = int'(slow_hi) + 1;
            4:       p = int'(fast_lo);
            5:       p = int'(fast_hi);
            6:       p = int'(fast_lo) - 1;
            7:       p = int'(fast_hi) + 1;
            8:       p = $urandom_range(0, 1) ? c - t : c + t;
            9:       p = $urandom_range(0, 1) ? c - t - 1 : c + t + 1;
            10:      p = c;
            default: p = int'($urandom_range(1, 2000));
        endcase
        if (p < 1) p = 1;
        return p;
    endfunction

    // A flashing stretch: alternating levels, each lasting about period ms.
    task automatic flash_run(input int unsigned period, input int unsigned segs,
                             input int unsigned glitch_pct);
        logic        level;
        int unsigned dur;

        level = ~last_raw;
        repeat (segs) begin
            dur = period;
            if ($urandom_range(0, 3) == 0) dur = period + $urandom_range(0, 2);
            send_segment(level, dur, glitch_pct);
            level = ~level;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset registers: first edge, opening, closing, fault, a short glitch,
    // steady closed and open, a timestamp wrap and a step backwards.
    task automatic test_directed_sequence();
        send_tick(1'b0, 32'd0);
        send_tick(1'b1, 32'd10);
        send_tick(1'b1, 32'd60);           // first edge, no period yet
        send_tick(1'b0, 32'd1060);
        send_tick(1'b0, 32'd1110);         // 1050 ms: slow band
        send_tick(1'b1, 32'd1410);
        send_tick(1'b1, 32'd1460);         // 350 ms: fast band
        send_tick(1'b0, 32'd1910);
        send_tick(1'b0, 32'd1960);         // 500 ms: fault band n = 2
        send_tick(1'b1, 32'd1970);         // glitch shorter than debounce
        send_tick(1'b0, 32'd1980);
        send_tick(1'b0, 32'd4960);         // steady dark: closed
        send_tick(1'b1, 32'd4970);
        send_tick(1'b1, 32'd5020);         // 3060 ms matches nothing: held
        send_tick(1'b1, 32'd8020);         // steady lit: open
        send_tick(1'b0, 32'hFFFF_FFFF);
        send_tick(1'b0, 32'h0000_0031);    // debounce across the wrap
        send_tick(1'b0, 32'h0000_0010);    // time steps backwards
        clock_ms = 32'h0001_0000;
    endtask

    // Register corners: overlapping bands, inverted bands with a huge
    // tolerance, all-zero and all-ones register sets, active-low lamp.
    task automatic test_register_extremes();
        fpsc_pkg::ms_time_t t;

        t = clock_ms;
        program_registers(16'd0, 16'hFFFF, 16'd100, 16'd600, 16'd100, 16'd600,
                          16'd0, 16'hFFFE);
        send_tick(1'b1, t);
        send_tick(1'b1, t + 1);
        send_tick(1'b0, t + 401);
        send_tick(1'b0, t + 402);          // both bands hold 401: slow wins

        program_registers(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd500, 16'd499,
                          16'hFFFF, 16'd1);
        send_tick(1'b1, t + 500);
        send_tick(1'b1, t + 501);          // fault band floor clamps to zero

        program_registers('0, '0, '0, '0, '0, '0, '0, '0);
        send_tick(1'b0, t + 600);
        send_tick(1'b0, t + 601);

        program_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 16'hFFFF);
        send_tick(1'b1, t + 700);
        send_tick(1'b1, t + 700 + 32'hFFFF);
        clock_ms = t + 32'h0002_0000;
    endtask

    // Clean flashing aimed at band edges and fault centres, with steady spells.
    task automatic test_band_matching();
        int unsigned goal;

        repeat (5) begin
            roll_registers(40, 1'b0);
            goal = ticks_sent + 200;
            while (ticks_sent < goal) begin
                pick_pacing();
                if ($urandom_range(0, 7) == 0)
                    steady_hold(1'($urandom_range(0, 1)));
                else
                    flash_run(pick_period(), $urandom_range(2, 6), 0);
            end
        end
    endtask

    // Long debounce times with flicker inside and around the window.
    task automatic test_debounce_glitches();
        int unsigned goal;
        int unsigned settle;

        repeat (2) begin
            roll_registers(300, 1'b0);
            goal = ticks_sent + 150;
            while (ticks_sent < goal) begin
                pick_pacing();
                settle = (deb_ms == 16'd0) ? 32'd1 : 32'(deb_ms);
                case ($urandom_range(0, 5))
                    0:       steady_hold(1'($urandom_range(0, 1)));
                    1:       flash_run(pick_period(), $urandom_range(2, 5), 35);
                    default: flash_run($urandom_range(1, 2 * settle + 2),
                                       $urandom_range(2, 6), 35);
                endcase
            end
        end
    endtask

    // Timestamps near the top of the range, jumps backwards and raw noise.
    task automatic test_timestamp_wrap();
        int unsigned goal;

        repeat (2) begin
            roll_registers(60, 1'b1);
            goal = ticks_sent + 150;
            while (ticks_sent < goal) begin
                pick_pacing();
                case ($urandom_range(0, 4))
                    0: begin
                        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
                        flash_run(pick_period(), $urandom_range(2, 5), 10);
                    end
                    1: begin
                        clock_ms = clock_ms - $urandom_range(1, 100000);
                        flash_run(pick_period(), $urandom_range(1, 3), 10);
                    end
                    2: begin
                        repeat ($urandom_range(1, 6)) begin
                            clock_ms = $urandom;
                            send_tick(1'($urandom_range(0, 1)), clock_ms);
                        end
                    end
                    3: steady_hold(1'($urandom_range(0, 1)));
                    default: flash_run(pick_period(), $urandom_range(2, 5), 0);
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_raw_sample = 1'b0;
        s_now_ms     = '0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        fails        = 0;
        ticks_sent   = 0;
        idle_cycles  = 0;
        running      = 1'b0;
        clock_ms     = '0;
        last_raw     = 1'b0;
        src_calm     = 1'b0;
        sink_calm    = 1'b0;
        clear_predictor();

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        running = 1'b1;

        test_directed_sequence();
        test_register_extremes();
        test_band_matching();
        test_debounce_glitches();
        test_timestamp_wrap();

        wait_idle();
        repeat (8) @(posedge aclk);
        if (fails == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
